// ----- design/normalized_2d_convolution_top_macros.svh -----
// ---------------------------------------------------------------------------
// normalized_2d_convolution_top_macros
// Assertion helpers for the normalized convolution block.
// ---------------------------------------------------------------------------
`ifndef NORMALIZED_2D_CONVOLUTION_TOP_MACROS_SVH
`define NORMALIZED_2D_CONVOLUTION_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define NC2D_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define NC2D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/nconv2d_pkg.sv -----
// ---------------------------------------------------------------------------
// nconv2d_pkg
// Sizes, field widths and codes of the normalized 2-D convolution block.
// ---------------------------------------------------------------------------
package nconv2d_pkg;

   localparam int MAX_KERNEL = 5;
   localparam int MAX_DIM    = 64;
   localparam int KSLOTS     = MAX_KERNEL * MAX_KERNEL;

   localparam int DIM_W   = 7;
   localparam int POS_W   = 6;
   localparam int KS_W    = 3;
   localparam int KIDX_W  = 5;
   localparam int VAL_W   = 16;
   localparam int PROD_W  = 2 * VAL_W;
   localparam int ACC_W   = 36;
   localparam int SUM_W   = 21;
   localparam int RING_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int LB_DEPTH = MAX_KERNEL * MAX_DIM;
   localparam int LB_AW   = $clog2(LB_DEPTH);
   localparam int DCNT_W  = $clog2(ACC_W);

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KSIZE  = 2'd2;

   localparam logic OP_COEF  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

endpackage

// ----- design/normalized_2d_convolution_top.sv -----
// ---------------------------------------------------------------------------
// normalized_2d_convolution_top
// Valid-region k by k correlation divided by the kernel coefficient sum.
// ---------------------------------------------------------------------------
// A coefficient item or a pixel that completes no window leaves the block
// ready for the next item. For a pixel that completes a window, k*k reads
// of the pixel line memory (one port, one read a cycle) feed a single 16x16
// multiply-accumulate, the pipeline drains, a 36-step restoring divider
// forms the quotient and S_DONE loads the result register once rsp_ is free.
// The next item is taken while a finished result still waits on rsp_; a
// second finished result waits for the first to leave. The input is held off
// in a cycle with a configuration write and during reset. Pixels of the last
// rows are kept in a line memory of MAX_KERNEL rows.
`include "normalized_2d_convolution_top_macros.svh"

module normalized_2d_convolution_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // coef_index [4:0], value [20:5], zero [23:21]
   input  logic [nconv2d_pkg::REQ_DATA_W-1:0] req_tdata,
   // op [0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result [35:0], out_row [41:36], out_col [47:42]
   output logic [nconv2d_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status [0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [nconv2d_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nconv2d_pkg::CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_DIV, S_DONE} state_type;

   localparam int DW = nconv2d_pkg::DIM_W;
   localparam int PW = nconv2d_pkg::POS_W;
   localparam int KW = nconv2d_pkg::KS_W;
   localparam int RW = nconv2d_pkg::RING_W;
   localparam int AW = nconv2d_pkg::LB_AW;
   localparam int VW = nconv2d_pkg::VAL_W;
   localparam int SW = nconv2d_pkg::SUM_W;
   localparam int QW = nconv2d_pkg::ACC_W;

   state_type state_ff;

   logic [DW-1:0] height_ff, width_ff;
   logic [KW-1:0] ksize_ff;
   logic [PW-1:0] row_ff, col_ff;
   logic [RW-1:0] rmod_ff;

   logic signed [VW-1:0] kernel_ff [nconv2d_pkg::KSLOTS];
   logic signed [VW-1:0] lb_mem [nconv2d_pkg::LB_DEPTH];
   logic signed [VW-1:0] lb_rd_ff;

   // Window walk
   logic [KW-1:0] k_ff, ii_ff, jj_ff;
   logic [RW-1:0] ring_ff;
   logic [nconv2d_pkg::KIDX_W-1:0] kidx_ff;
   logic [PW-1:0] r0_ff, c0_ff;
   logic          last_ff;

   // MAC pipeline
   logic                 v1_ff, v2_ff;
   logic signed [VW-1:0] coef_ff;
   logic signed [nconv2d_pkg::PROD_W-1:0] prod_ff;
   logic signed [QW-1:0] acc_ff;
   logic signed [SW-1:0] ksum_ff;

   // Divider
   logic [QW-1:0] num_ff;
   logic [SW-1:0] rem_ff, den_ff;
   logic [nconv2d_pkg::DCNT_W-1:0] dcnt_ff;
   logic          neg_ff, status_ff;

   logic          rsp_valid_ff;
   logic [QW-1:0] rsp_result_ff;
   logic [PW-1:0] rsp_row_ff, rsp_col_ff;
   logic          rsp_status_ff, rsp_last_ff;

   // Input decode
   logic                 req_fire, pix_fire, coef_fire;
   logic [nconv2d_pkg::KIDX_W-1:0] req_idx;
   logic signed [VW-1:0] req_val;
   logic [DW-1:0] h_eff, w_eff;
   logic [PW-1:0] r_cur, c_cur;
   logic [RW-1:0] rm_cur, rm_next, start_ring;
   logic [RW:0]   start_sum;
   logic          kvalid, emit, lastpix, row_end;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          issuing, out_free;
   logic [SW:0]   trial;
   logic [QW-1:0] acc_mag;
   logic [SW-1:0] ksum_mag;

   assign req_idx   = req_tdata[nconv2d_pkg::KIDX_W-1:0];
   assign req_val   = req_tdata[nconv2d_pkg::KIDX_W +: VW];
   // A configuration write takes the cycle; the item waits behind it.
   assign req_tready = (state_ff == S_IDLE) && !csr_valid && !reset;
   assign req_fire  = req_tvalid && req_tready;
   assign pix_fire  = req_fire && (req_tuser == nconv2d_pkg::OP_PIXEL);
   assign coef_fire = req_fire && (req_tuser == nconv2d_pkg::OP_COEF);
   assign csr_ready = !reset;

   always_comb begin
      h_eff = height_ff;
      if (height_ff == '0) h_eff = DW'(1);
      else if (height_ff > DW'(nconv2d_pkg::MAX_DIM)) h_eff = DW'(nconv2d_pkg::MAX_DIM);
      w_eff = width_ff;
      if (width_ff == '0) w_eff = DW'(1);
      else if (width_ff > DW'(nconv2d_pkg::MAX_DIM)) w_eff = DW'(nconv2d_pkg::MAX_DIM);
   end

   always_comb begin
      r_cur  = ({1'b0, row_ff} >= h_eff) ? '0 : row_ff;
      rm_cur = ({1'b0, row_ff} >= h_eff) ? '0 : rmod_ff;
      c_cur  = ({1'b0, col_ff} >= w_eff) ? '0 : col_ff;
      kvalid = ksize_ff[0] && (ksize_ff <= KW'(nconv2d_pkg::MAX_KERNEL))
               && (DW'(ksize_ff) < h_eff) && (DW'(ksize_ff) < w_eff);
      emit   = kvalid && (DW'(r_cur) + DW'(1) >= DW'(ksize_ff))
               && (DW'(c_cur) + DW'(1) >= DW'(ksize_ff));
      lastpix = (DW'(r_cur) + DW'(1) == h_eff) && (DW'(c_cur) + DW'(1) == w_eff);
      row_end = (DW'(c_cur) + DW'(1) >= w_eff);
      rm_next = (rm_cur == RW'(nconv2d_pkg::MAX_KERNEL - 1)) ? '0 : rm_cur + RW'(1);
      // Ring row of the window's top row: (rm_cur + 1 - k) mod MAX_KERNEL.
      start_sum = (RW+1)'(rm_cur) + (RW+1)'(nconv2d_pkg::MAX_KERNEL + 1)
                  - (RW+1)'(ksize_ff);
      start_ring = (start_sum >= (RW+1)'(nconv2d_pkg::MAX_KERNEL))
                   ? RW'(start_sum - (RW+1)'(nconv2d_pkg::MAX_KERNEL)) : RW'(start_sum);
      wr_addr = AW'(rm_cur) * AW'(nconv2d_pkg::MAX_DIM) + AW'(c_cur);
      rd_addr = AW'(ring_ff) * AW'(nconv2d_pkg::MAX_DIM) + AW'(c0_ff) + AW'(jj_ff);
      issuing = (state_ff == S_MAC);
      out_free = !rsp_valid_ff || rsp_tready;
      trial = {rem_ff, num_ff[QW-1]};
      acc_mag  = acc_ff[QW-1] ? QW'(-acc_ff) : QW'(acc_ff);
      ksum_mag = ksum_ff[SW-1] ? SW'(-ksum_ff) : SW'(ksum_ff);
   end

   // Pixel line memory: one write at accept, one read a cycle during the walk.
   always_ff @(posedge clock) begin
      if (pix_fire) begin
         lb_mem[wr_addr] <= req_val;
      end
      if (issuing) begin
         lb_rd_ff <= lb_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < nconv2d_pkg::KSLOTS; i++) begin
            kernel_ff[i] <= '0;
         end
      end else if (coef_fire && (req_idx < nconv2d_pkg::KIDX_W'(nconv2d_pkg::KSLOTS))) begin
         kernel_ff[req_idx] <= req_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         height_ff    <= DW'(nconv2d_pkg::MAX_DIM);
         width_ff     <= DW'(nconv2d_pkg::MAX_DIM);
         ksize_ff     <= KW'(3);
         row_ff       <= '0;
         col_ff       <= '0;
         rmod_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= issuing;
         v2_ff <= v1_ff;
         if (v1_ff) prod_ff <= lb_rd_ff * coef_ff;
         if (v2_ff) acc_ff <= acc_ff + QW'(prod_ff);
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;

         if (csr_valid && csr_ready) begin
            case (csr_index)
               nconv2d_pkg::REG_HEIGHT: height_ff <= csr_data;
               nconv2d_pkg::REG_WIDTH:  width_ff  <= csr_data;
               nconv2d_pkg::REG_KSIZE:  ksize_ff  <= csr_data[KW-1:0];
               default: ;
            endcase
            if (csr_index <= nconv2d_pkg::REG_KSIZE) begin
               row_ff  <= '0;
               col_ff  <= '0;
               rmod_ff <= '0;
            end
         end

         case (state_ff)
            S_IDLE: begin
               if (pix_fire) begin
                  if (row_end) begin
                     col_ff <= '0;
                     if (DW'(r_cur) + DW'(1) >= h_eff) begin
                        row_ff  <= '0;
                        rmod_ff <= '0;
                     end else begin
                        row_ff  <= r_cur + PW'(1);
                        rmod_ff <= rm_next;
                     end
                  end else begin
                     row_ff  <= r_cur;
                     rmod_ff <= rm_cur;
                     col_ff  <= c_cur + PW'(1);
                  end
                  if (emit) begin
                     k_ff    <= ksize_ff;
                     ii_ff   <= '0;
                     jj_ff   <= '0;
                     kidx_ff <= '0;
                     ring_ff <= start_ring;
                     r0_ff   <= r_cur + PW'(1) - PW'(ksize_ff);
                     c0_ff   <= c_cur + PW'(1) - PW'(ksize_ff);
                     last_ff <= lastpix;
                     acc_ff  <= '0;
                     ksum_ff <= '0;
                     state_ff <= S_MAC;
                  end
               end
            end
            S_MAC: begin
               coef_ff <= kernel_ff[kidx_ff];
               ksum_ff <= ksum_ff + SW'(kernel_ff[kidx_ff]);
               kidx_ff <= kidx_ff + nconv2d_pkg::KIDX_W'(1);
               if (jj_ff == k_ff - KW'(1)) begin
                  jj_ff <= '0;
                  ii_ff <= ii_ff + KW'(1);
                  ring_ff <= (ring_ff == RW'(nconv2d_pkg::MAX_KERNEL - 1))
                             ? '0 : ring_ff + RW'(1);
                  if (ii_ff == k_ff - KW'(1)) state_ff <= S_DRAIN;
               end else begin
                  jj_ff <= jj_ff + KW'(1);
               end
            end
            S_DRAIN: begin
               if (!v1_ff && !v2_ff) begin
                  num_ff  <= acc_mag;
                  den_ff  <= ksum_mag;
                  rem_ff  <= '0;
                  neg_ff  <= acc_ff[QW-1] ^ ksum_ff[SW-1];
                  dcnt_ff <= nconv2d_pkg::DCNT_W'(QW - 1);
                  if (ksum_ff == '0) begin
                     status_ff <= 1'b1;
                     num_ff    <= '0;
                     neg_ff    <= 1'b0;
                     state_ff  <= S_DONE;
                  end else begin
                     status_ff <= 1'b0;
                     state_ff  <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               // One restoring step a cycle; the quotient shifts into num_ff.
               if (trial >= {1'b0, den_ff}) begin
                  rem_ff <= SW'(trial - {1'b0, den_ff});
                  num_ff <= {num_ff[QW-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[SW-1:0];
                  num_ff <= {num_ff[QW-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff - nconv2d_pkg::DCNT_W'(1);
               if (dcnt_ff == '0) state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_result_ff <= neg_ff ? QW'(-num_ff) : num_ff;
                  rsp_row_ff    <= r0_ff;
                  rsp_col_ff    <= c0_ff;
                  rsp_status_ff <= status_ff;
                  rsp_last_ff   <= last_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_col_ff, rsp_row_ff, rsp_result_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   `NC2D_ASSERT_NEXT(a_emit_starts_walk, clock, reset,
      (pix_fire && emit), (state_ff == S_MAC), "window pixel did not start the walk")
   `NC2D_ASSERT_NEXT(a_div_ends, clock, reset,
      (state_ff == S_DIV && dcnt_ff == '0), (state_ff == S_DONE), "divider overran")
   `NC2D_ASSERT_SAME(a_zero_sum_result, clock, reset,
      (rsp_valid_ff && rsp_status_ff), (rsp_result_ff == '0), "zero sum, nonzero result")
   `NC2D_ASSERT_SAME(a_drain_idle_mac, clock, reset,
      (state_ff == S_DIV), (!v1_ff && !v2_ff), "divider started before the MAC drained")

endmodule

// ----- dv/normalized_2d_convolution_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// normalized_2d_convolution_top_tb
// Drives kernel coefficients and pixels into the convolution block and checks
// every window result against a cycle-free predictor of the block.
// ----------------------------------------------------------------------------
module normalized_2d_convolution_top_tb;

   typedef struct packed {
      logic [nconv2d_pkg::ACC_W-1:0] quotient;
      logic [nconv2d_pkg::POS_W-1:0] row;
      logic [nconv2d_pkg::POS_W-1:0] col;
      logic                          zero_sum;
      logic                          frame_end;
   } window_result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [nconv2d_pkg::REQ_DATA_W-1:0] req_tdata;
   logic req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [nconv2d_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_valid;
   logic csr_ready;
   logic [nconv2d_pkg::CSR_IDX_W-1:0] csr_index;
   logic [nconv2d_pkg::CSR_DATA_W-1:0] csr_data;

   normalized_2d_convolution_top dut (.*);

   // Predictor copy of the block state.
   int unsigned img_height, img_width, ksize;
   int          coef_mem [nconv2d_pkg::KSLOTS];
   int          pixel_lines [nconv2d_pkg::MAX_KERNEL][nconv2d_pkg::MAX_DIM];
   int unsigned cur_row, cur_col;

   window_result_type pending_results [$];
   int  mismatches;
   bit  idling_on;
   int  rsp_hold_cycles;
   int  items_sent;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int unsigned clamp_dim(int unsigned d);
      if (d == 0) return 1;
      if (d > nconv2d_pkg::MAX_DIM) return nconv2d_pkg::MAX_DIM;
      return d;
   endfunction

   function automatic void apply_register(logic [nconv2d_pkg::CSR_IDX_W-1:0] idx,
                                          logic [nconv2d_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         nconv2d_pkg::REG_HEIGHT: img_height = data;
         nconv2d_pkg::REG_WIDTH:  img_width = data;
         nconv2d_pkg::REG_KSIZE:  ksize = data[nconv2d_pkg::KS_W-1:0];
         default: return;
      endcase
      cur_row = 0;
      cur_col = 0;
   endfunction

   // Updates the state for one accepted item and queues a window result when it completes one.
   function automatic void predict_window(logic op, logic [nconv2d_pkg::KIDX_W-1:0] idx,
                                          logic signed [nconv2d_pkg::VAL_W-1:0] val);
      int unsigned h, w, r, c, r0, c0;
      bit ok_kernel;
      longint acc, q;
      int coef_total;
      window_result_type res;
      if (op == nconv2d_pkg::OP_COEF) begin
         if (idx < nconv2d_pkg::KSLOTS) coef_mem[idx] = val;
         return;
      end
      h = clamp_dim(img_height);
      w = clamp_dim(img_width);
      r = (cur_row >= h) ? 0 : cur_row;
      c = (cur_col >= w) ? 0 : cur_col;
      pixel_lines[r % nconv2d_pkg::MAX_KERNEL][c] = val;
      ok_kernel = ksize[0] && ksize <= nconv2d_pkg::MAX_KERNEL && ksize < h && ksize < w;
      if (ok_kernel && r + 1 >= ksize && c + 1 >= ksize) begin
         r0 = r + 1 - ksize;
         c0 = c + 1 - ksize;
         acc = 0;
         coef_total = 0;
         q = 0;
         for (int i = 0; i < ksize; i++)
            for (int j = 0; j < ksize; j++) begin
               acc += longint'(pixel_lines[(r0 + i) % nconv2d_pkg::MAX_KERNEL][c0 + j])
                      * longint'(coef_mem[i * ksize + j]);
               coef_total += coef_mem[i * ksize + j];
            end
         if (coef_total != 0) q = acc / longint'(coef_total);
         res.quotient = q[nconv2d_pkg::ACC_W-1:0];
         res.row = r0[nconv2d_pkg::POS_W-1:0];
         res.col = c0[nconv2d_pkg::POS_W-1:0];
         res.zero_sum = (coef_total == 0);
         res.frame_end = (r + 1 == h) && (c + 1 == w);
         pending_results.push_back(res);
      end
      if (c + 1 >= w) begin
         c = 0;
         r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         c++;
      end
      cur_row = r;
      cur_col = c;
   endfunction

   // Result checker.
   always @(posedge clock) begin
      window_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.quotient  = rsp_tdata[35:0];
         got.row       = rsp_tdata[41:36];
         got.col       = rsp_tdata[47:42];
         got.zero_sum  = rsp_tuser;
         got.frame_end = rsp_tlast;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p, actual %p", want, got);
            end
         end
      end
   end

   // Result receiver with random stall bursts and a long hold on request.
   initial begin
      int stall;
      stall = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(0, 16);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Leaves req_tvalid high on return; the caller sends again or stops.
   task automatic send_item(logic op, logic [nconv2d_pkg::KIDX_W-1:0] idx,
                            logic [nconv2d_pkg::VAL_W-1:0] val);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, val, idx};
      do @(posedge clock); while (!req_tready);
      predict_window(op, idx, val);
      items_sent++;
   endtask

   task automatic stop_items();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      stop_items();
      wait (pending_results.size() == 0);
      // Leaves room for any stray result to show up before the next step.
      repeat (100) @(posedge clock);
   endtask

   task automatic write_register(logic [nconv2d_pkg::CSR_IDX_W-1:0] idx,
                                 logic [nconv2d_pkg::CSR_DATA_W-1:0] data);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(int h, int w, int k);
      write_register(nconv2d_pkg::REG_HEIGHT, nconv2d_pkg::CSR_DATA_W'(h));
      write_register(nconv2d_pkg::REG_WIDTH, nconv2d_pkg::CSR_DATA_W'(w));
      write_register(nconv2d_pkg::REG_KSIZE, nconv2d_pkg::CSR_DATA_W'(k));
   endtask

   task automatic send_pixels(int count);
      for (int i = 0; i < count; i++)
         send_item(nconv2d_pkg::OP_PIXEL, nconv2d_pkg::KIDX_W'($urandom),
                   nconv2d_pkg::VAL_W'($urandom));
   endtask

   task automatic test_one_tap_extremes();
      set_geometry(2, 3, 1);
      send_item(nconv2d_pkg::OP_COEF, 5'd0, 16'h8000);
      send_item(nconv2d_pkg::OP_COEF, 5'd31, 16'h0005);   // index past the store, dropped
      send_item(nconv2d_pkg::OP_COEF, 5'd24, 16'h7fff);   // stored but outside a 1x1 kernel
      send_item(nconv2d_pkg::OP_PIXEL, 5'd0, 16'h7fff);
      send_item(nconv2d_pkg::OP_PIXEL, 5'd0, 16'h8000);
      send_item(nconv2d_pkg::OP_PIXEL, 5'd0, 16'hffff);
      send_item(nconv2d_pkg::OP_PIXEL, 5'd0, 16'h0000);
      send_item(nconv2d_pkg::OP_PIXEL, 5'd0, 16'h0001);
      send_item(nconv2d_pkg::OP_PIXEL, 5'd0, 16'h7fff);
      send_item(nconv2d_pkg::OP_PIXEL, 5'd0, 16'h1234);   // wraps into a new image
      drain_results();
   endtask

   task automatic test_zero_sum_kernel();
      set_geometry(3, 4, 3);
      for (int i = 0; i < 9; i++)
         send_item(nconv2d_pkg::OP_COEF, nconv2d_pkg::KIDX_W'(i),
                   (i == 0) ? 16'h7fff : (i == 8) ? 16'h8001 : 16'h0000);
      send_pixels(12);
      drain_results();
   endtask

   task automatic test_bad_kernel_sizes();
      for (int k = 0; k < 8; k += 2) begin
         set_geometry(4, 6, k);
         send_pixels(3);
      end
      set_geometry(5, 6, 5);             // not below the height
      send_pixels(4);
      set_geometry(0, 127, 7);           // clamped dimensions, oversized kernel
      send_pixels(3);
      drain_results();
   endtask

   task automatic test_backpressure();
      set_geometry(3, 8, 1);
      send_item(nconv2d_pkg::OP_COEF, 5'd0, 16'h0003);
      rsp_hold_cycles = 400;
      send_pixels(48);
      drain_results();
   endtask

   task automatic test_random_images();
      int h, w, k, n, sel;
      while (items_sent < 2000) begin
         idling_on = (items_sent < 1600);
         sel = $urandom_range(0, 19);
         h = (sel == 0) ? $urandom_range(0, 127) : (sel == 1) ? 64 : $urandom_range(2, 9);
         w = (sel == 2) ? $urandom_range(0, 127) : (sel == 3) ? 64 : $urandom_range(2, 9);
         k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 2 * $urandom_range(0, 2) + 1;
         set_geometry(h, w, k);
         sel = $urandom_range(0, 3);
         for (int i = 0; i < nconv2d_pkg::KSLOTS; i++) begin
            if (sel == 0)
               send_item(nconv2d_pkg::OP_COEF, nconv2d_pkg::KIDX_W'(i),
                         nconv2d_pkg::VAL_W'($urandom));
            else if (sel == 3)
               send_item(nconv2d_pkg::OP_COEF, nconv2d_pkg::KIDX_W'(i),
                         nconv2d_pkg::VAL_W'($urandom_range(0, 2) - 1));
            else
               send_item(nconv2d_pkg::OP_COEF, nconv2d_pkg::KIDX_W'(i),
                         nconv2d_pkg::VAL_W'($urandom_range(0, 16) - 4));
         end
         if ($urandom_range(0, 4) == 0)
            send_item(nconv2d_pkg::OP_COEF, nconv2d_pkg::KIDX_W'($urandom_range(25, 31)),
                      nconv2d_pkg::VAL_W'($urandom));
         n = clamp_dim(h) * clamp_dim(w) * $urandom_range(1, 2) + $urandom_range(0, 5);
         send_pixels((n > 150) ? 150 : n);
      end
      drain_results();
   endtask

   initial begin
      mismatches = 0;
      items_sent = 0;
      idling_on = 1'b1;
      rsp_hold_cycles = 0;
      img_height = nconv2d_pkg::MAX_DIM;
      img_width = nconv2d_pkg::MAX_DIM;
      ksize = 3;
      cur_row = 0;
      cur_col = 0;
      foreach (coef_mem[i]) coef_mem[i] = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= nconv2d_pkg::OP_COEF;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_index <= nconv2d_pkg::REG_HEIGHT;
      csr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_one_tap_extremes();
      test_zero_sum_kernel();
      test_bad_kernel_sizes();
      test_backpressure();
      test_random_images();
      if (mismatches == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/nconv2d_pkg.sv
design/normalized_2d_convolution_top.sv
dv/normalized_2d_convolution_top_tb.sv
